[hw/rtl/gtf_pkg.sv]
// ----------------------------------------------------------------------------
// gtf_pkg: shared types and constants for the GTF mode timing calculator
// Widths, reciprocal constants for divide-by-constant and pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package gtf_pkg;

  localparam int W_W   = 12;   // active width / height
  localparam int VT_W  = 13;   // total lines
  localparam int VF_W  = 20;   // line rate in Hz
  localparam int Q1_W  = 9;    // (h+1)/k quotient
  localparam int F_W   = 7;    // refresh register

  localparam logic [F_W-1:0] REFRESH_RST = 7'd60;

  // divider depths (one quotient bit per stage)
  localparam int QK_W  = 11;   // k divider
  localparam int QA_W  = 9;    // (h+1)/k
  localparam int QB_W  = 15;   // line period in units of 10/3 ns
  localparam int QC_W  = 9;    // blanking per pixel ratio

  // stages outside the dividers, input capture to output register
  localparam int FIX_STAGES = 13;
  localparam int LATENCY    = FIX_STAGES + QA_W + QB_W + QC_W;

  // reciprocals: floor(x/N) == (x*M) >> S over the ranges in use
  localparam logic [17:0] RECIP_1000_S = 18'd134218;       // shift 27
  localparam logic [31:0] RECIP_1000_L = 32'd2199023256;   // shift 41
  localparam logic [13:0] RECIP_100    = 14'd10486;        // shift 20
  localparam logic [21:0] RECIP_10     = 22'd3355444;      // shift 25

  typedef struct packed {
    logic [W_W-1:0]  w;
    logic [W_W-1:0]  h;
    logic [Q1_W-1:0] q1;
    logic [VT_W-1:0] vt;
    logic [VF_W-1:0] vf;
    logic            sat;
  } item_t;

endpackage

`default_nettype wire

[hw/rtl/gtf_mode_timing_calc.sv]
// ----------------------------------------------------------------------------
// gtf_mode_timing_calc: simplified GTF video timing calculator
// Computes totals, blanking, sync positions and pixel clock for one
// requested active resolution at the configured refresh rate.
// ----------------------------------------------------------------------------
//  channel  | ports                                | transfer
//  ---------+--------------------------------------+----------------------------
//  request  | start, busy, in_width, in_height     | start high while busy low
//  result   | out_valid, out_*                     | one cycle with out_valid
//  config   | cfg_we, cfg_wdata (refresh in Hz)    | cfg_we high
//
// One request per cycle while busy is low; results leave in request order.
// Most of the depth lies in the three bit-serial dividers (9, 15, 9 stages).
// After reset and after each refresh write, busy stays high while the line
// divisor k is recomputed by an 11-stage divider.
// The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_mode_timing_calc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] in_width,
  input  wire logic [11:0] in_height,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  output logic             out_valid,
  output logic [22:0]      out_clock_khz,
  output logic [15:0]      out_pixel_clock_10khz,
  output logic [12:0]      out_h_sync_start,
  output logic [12:0]      out_h_sync_end,
  output logic [12:0]      out_h_blank_end,
  output logic [12:0]      out_v_sync_start,
  output logic [12:0]      out_v_sync_end,
  output logic [12:0]      out_v_blank_end,
  output logic [11:0]      out_h_blank_pixels,
  output logic [9:0]       out_h_sync_offset,
  output logic [9:0]       out_h_sync_pulse,
  output logic [11:0]      out_v_blank_pixels
);

  localparam int KLOAD = gtf_pkg::QK_W + 1;
  localparam int KC_W  = $clog2(KLOAD + 1);
  localparam int IT_W  = $bits(gtf_pkg::item_t);

  // --------------------------------------------------------------------------
  // refresh register and line divisor k
  // --------------------------------------------------------------------------
  logic [6:0]      refresh_r;
  logic            kstart_r;
  logic [KC_W-1:0] kcnt_r;
  logic [10:0]     k_r;
  logic [6:0]      f_eff;
  logic [10:0]     t_w;
  logic [14:0]     kn_w;
  logic            kq_v;
  logic [10:0]     kq;

  assign f_eff = (refresh_r == '0) ? 7'd1 : refresh_r;
  assign t_w   = 11'(f_eff) * 11'd11;
  assign kn_w  = 15'd20000 + 15'(t_w >> 1);
  assign busy  = (kcnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= gtf_pkg::REFRESH_RST;
      kstart_r  <= 1'b1;
      kcnt_r    <= KC_W'(KLOAD);
    end else begin
      kstart_r <= cfg_we;
      if (cfg_we) begin
        refresh_r <= cfg_wdata;
        kcnt_r    <= KC_W'(KLOAD);
      end else if (kcnt_r != '0) begin
        kcnt_r <= kcnt_r - 1'b1;
      end
    end
  end

  gtf_div_pipe #(.NW(15), .DW(11), .QW(gtf_pkg::QK_W), .SW(1)) u_div_k (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (kstart_r),
    .in_num  (kn_w),
    .in_den  (t_w),
    .in_side (1'b0),
    .out_vld (kq_v),
    .out_quo (kq),
    .out_side()
  );

  always_ff @(posedge clk) begin
    if (kq_v) begin
      k_r <= kq - 11'd1;
    end
  end

  // --------------------------------------------------------------------------
  // S0: capture request
  // --------------------------------------------------------------------------
  logic            s0_v_r;
  gtf_pkg::item_t  s0_it_r;
  gtf_pkg::item_t  s0_it_nxt;

  always_comb begin
    s0_it_nxt   = '0;
    s0_it_nxt.w = in_width;
    s0_it_nxt.h = in_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
    s0_it_r <= s0_it_nxt;
  end

  // (h+1)/k
  logic            a_v;
  logic [8:0]      a_q;
  logic [IT_W-1:0] a_side;
  gtf_pkg::item_t  a_it;

  gtf_div_pipe #(.NW(13), .DW(11), .QW(gtf_pkg::QA_W), .SW(IT_W)) u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_v_r),
    .in_num  (13'(s0_it_r.h) + 13'd1),
    .in_den  (k_r),
    .in_side (s0_it_r),
    .out_vld (a_v),
    .out_quo (a_q),
    .out_side(a_side)
  );
  assign a_it = gtf_pkg::item_t'(a_side);

  // --------------------------------------------------------------------------
  // S1..S3: total lines, line rate, period dividend
  // --------------------------------------------------------------------------
  logic           s1_v_r, s2_v_r, s3_v_r;
  gtf_pkg::item_t s1_it_r, s2_it_r, s3_it_r;
  gtf_pkg::item_t s1_it_nxt, s2_it_nxt, s3_it_nxt;
  logic [28:0]    s3_num_r;
  logic [28:0]    hpn_w;
  logic           sat_w;

  assign hpn_w = 29'd300000000 + 29'(s2_it_r.vf >> 1);
  assign sat_w = 35'(hpn_w) >= {s2_it_r.vf, 15'b0};

  always_comb begin
    s1_it_nxt     = a_it;
    s1_it_nxt.q1  = a_q;
    s1_it_nxt.vt  = 13'(a_it.h) + 13'(a_q) + 13'd1;
    s2_it_nxt     = s1_it_r;
    s2_it_nxt.vf  = 20'(s1_it_r.vt) * 20'(f_eff);
    s3_it_nxt     = s2_it_r;
    s3_it_nxt.sat = sat_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= a_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    s1_it_r  <= s1_it_nxt;
    s2_it_r  <= s2_it_nxt;
    s3_it_r  <= s3_it_nxt;
    // keep the divider in range when the period is saturated anyway
    s3_num_r <= sat_w ? '0 : hpn_w;
  end

  // line period in units of 10/3 ns
  logic            b_v;
  logic [14:0]     b_q;
  logic [IT_W-1:0] b_side;
  gtf_pkg::item_t  b_it;

  gtf_div_pipe #(.NW(29), .DW(20), .QW(gtf_pkg::QB_W), .SW(IT_W)) u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s3_v_r),
    .in_num  (s3_num_r),
    .in_den  (s3_it_r.vf),
    .in_side (s3_it_r),
    .out_vld (b_v),
    .out_quo (b_q),
    .out_side(b_side)
  );
  assign b_it = gtf_pkg::item_t'(b_side);

  // --------------------------------------------------------------------------
  // S4..S5: blanking ratio dividend and divisor
  // --------------------------------------------------------------------------
  logic           s4_v_r, s5_v_r;
  gtf_pkg::item_t s4_it_r, s5_it_r;
  logic [24:0]    s4_d_r, s5_num_r;
  logic [16:0]    s4_c_r, s5_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s4_v_r <= b_v;
      s5_v_r <= s4_v_r;
    end
    s4_it_r <= b_it;
    // long line period: no blanking
    if (b_it.sat || b_q > 15'd30000) begin
      s4_d_r <= '0;
    end else begin
      s4_d_r <= 25'(15'd30000 - b_q) * 25'd1000;
    end
    s4_c_r <= 17'd70000 + 17'(b_q);

    s5_it_r  <= s4_it_r;
    s5_num_r <= s4_d_r + 25'(s4_c_r >> 1);
    s5_c_r   <= s4_c_r;
  end

  logic            c_v;
  logic [8:0]      c_q;
  logic [IT_W-1:0] c_side;
  gtf_pkg::item_t  c_it;

  gtf_div_pipe #(.NW(25), .DW(17), .QW(gtf_pkg::QC_W), .SW(IT_W)) u_div_c (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s5_v_r),
    .in_num  (s5_num_r),
    .in_den  (s5_c_r),
    .in_side (s5_it_r),
    .out_vld (c_v),
    .out_quo (c_q),
    .out_side(c_side)
  );
  assign c_it = gtf_pkg::item_t'(c_side);

  // --------------------------------------------------------------------------
  // S6..S11: blanking, totals, pixel clock
  // --------------------------------------------------------------------------
  logic           s6_v_r, s7_v_r, s8_v_r, s9_v_r, s10_v_r, s11_v_r;
  gtf_pkg::item_t s6_it_r, s7_it_r, s8_it_r, s9_it_r, s10_it_r, s11_it_r;
  logic [20:0]    s6_hb0_r;
  logic [34:0]    s7_prod_r;
  logic [10:0]    s8_hb_r, s9_hb_r, s10_hb_r, s11_hb_r;
  logic [12:0]    s8_tot_r, s9_tot_r, s10_tot_r, s11_tot_r;
  logic [31:0]    s9_p_r;
  logic [27:0]    s9_ym_r;
  logic [22:0]    s10_ck_r, s11_ck_r;
  logic [12:0]    s10_hsw_r, s11_hsw_r;
  logic [44:0]    s11_pp_r;
  logic [16:0]    hb1_w;
  logic [63:0]    ck_prod_w;

  assign hb1_w     = 17'((s6_hb0_r + 21'd8) >> 4);
  assign ck_prod_w = 64'(s9_p_r) * 64'(gtf_pkg::RECIP_1000_L);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      s11_v_r <= 1'b0;
    end else begin
      s6_v_r  <= c_v;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
    end
    s6_it_r  <= c_it;
    s6_hb0_r <= 21'(c_it.w) * 21'(c_q);

    // round to 16, then to a multiple of 1000 (scaled by 16)
    s7_it_r   <= s6_it_r;
    s7_prod_r <= 35'(hb1_w + 17'd500) * 35'(gtf_pkg::RECIP_1000_S);

    s8_it_r  <= s7_it_r;
    s8_hb_r  <= 11'({s7_prod_r[34:27], 4'b0});
    s8_tot_r <= 13'(s7_it_r.w) + 13'({s7_prod_r[34:27], 4'b0});

    s9_it_r  <= s8_it_r;
    s9_hb_r  <= s8_hb_r;
    s9_tot_r <= s8_tot_r;
    s9_p_r   <= 32'(s8_tot_r) * 32'(s8_it_r.vf);
    s9_ym_r  <= 28'(14'(s8_tot_r) + 14'd50) * 28'(gtf_pkg::RECIP_100);

    s10_it_r  <= s9_it_r;
    s10_hb_r  <= s9_hb_r;
    s10_tot_r <= s9_tot_r;
    s10_ck_r  <= ck_prod_w[63:41];
    s10_hsw_r <= 13'({s9_ym_r[27:20], 3'b0});

    s11_it_r  <= s10_it_r;
    s11_hb_r  <= s10_hb_r;
    s11_tot_r <= s10_tot_r;
    s11_ck_r  <= s10_ck_r;
    s11_hsw_r <= s10_hsw_r;
    s11_pp_r  <= 45'(s10_ck_r) * 45'(gtf_pkg::RECIP_10);
  end

  // --------------------------------------------------------------------------
  // S12: output register
  // --------------------------------------------------------------------------
  logic [12:0] hse_w, hss_w;

  assign hse_w = 13'(s11_it_r.w) + 13'(s11_hb_r >> 1) - 13'd1;
  assign hss_w = hse_w - s11_hsw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s11_v_r;
    end
    out_clock_khz         <= s11_ck_r;
    out_pixel_clock_10khz <= s11_pp_r[40:25];
    out_h_sync_start      <= hss_w;
    out_h_sync_end        <= hse_w;
    out_h_blank_end       <= s11_tot_r - 13'd1;
    out_v_sync_start      <= 13'(s11_it_r.h);
    out_v_sync_end        <= 13'(s11_it_r.h) + 13'd3;
    out_v_blank_end       <= s11_it_r.vt - 13'd1;
    out_h_blank_pixels    <= 12'(s11_hb_r) - 12'd1;
    out_h_sync_offset     <= 10'(hss_w - 13'(s11_it_r.w));
    out_h_sync_pulse      <= 10'(s11_hsw_r);
    out_v_blank_pixels    <= 12'(s11_it_r.q1);
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(gtf_pkg::LATENCY) out_valid)
    else $error("result missing after request transfer");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("request taken while k is recomputed");

  a_vsync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_v_sync_end == out_v_sync_start + 13'd3))
    else $error("vertical sync width wrong");

  a_hblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_h_blank_pixels[3:0] == 4'hF))
    else $error("horizontal blanking not a multiple of 16");

  a_hpulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_h_sync_pulse[2:0] == 3'b000))
    else $error("horizontal sync pulse not a multiple of 8");

endmodule

`default_nettype wire

[hw/rtl/gtf_div_pipe.sv]
// ----------------------------------------------------------------------------
// gtf_div_pipe: pipelined restoring divider
// One quotient bit per stage, a new division may enter every cycle.
// The quotient must fit in QW bits (num < den * 2**QW).
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_div_pipe #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [QW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic          vld_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [CW-1:0] rem_i;
    logic [CW-1:0] sub_w;
    logic [DW-1:0] den_i;
    logic [QW-1:0] quo_i;
    logic [SW-1:0] side_i;
    logic          vld_i;

    if (s == 0) begin : g_first
      assign rem_i  = CW'(in_num);
      assign den_i  = in_den;
      assign quo_i  = '0;
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = CW'(rem_r[s-1]);
      assign den_i  = den_r[s-1];
      assign quo_i  = quo_r[s-1];
      assign side_i = side_r[s-1];
      assign vld_i  = vld_r[s-1];
    end

    assign sub_w = CW'(den_i) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
      den_r[s]  <= den_i;
      side_r[s] <= side_i;
      if (rem_i >= sub_w) begin
        rem_r[s] <= NW'(rem_i - sub_w);
        quo_r[s] <= quo_i | (QW'(1) << B);
      end else begin
        rem_r[s] <= NW'(rem_i);
        quo_r[s] <= quo_i;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

`default_nettype wire
